// ===== design/pbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbl_pkg: shared types for the positional byte list
// Operation and status codes, control state, and the command that is
// broadcast to every storage cell of the list.
// ----------------------------------------------------------------------------
package pbl_pkg;

    // Index width into the cell row; covers rows of up to 64 cells
    localparam int IDX_MAX_W = 6;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_INS_POS  = 3'd3,
        OP_RM_HEAD  = 3'd4,
        OP_RM_TAIL  = 3'd5,
        OP_RM_POS   = 3'd6,
        OP_READ     = 3'd7
    } pbl_op_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BADPOS = 3'd2,
        ST_FULL   = 3'd3,
        ST_ELEM   = 3'd4
    } pbl_status_t;

    typedef enum logic [0:0] {
        PBL_IDLE = 1'b0,
        PBL_READ = 1'b1
    } pbl_state_t;

    // What each cell does this cycle
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_ROT  = 2'd3
    } pbl_cmd_t;

    typedef struct packed {
        pbl_cmd_t               cmd;
        logic [IDX_MAX_W-1:0]   tgt;       // insert or remove index
        logic [IDX_MAX_W-1:0]   last_idx;  // index of the tail element
        logic [7:0]             value;     // byte to insert
    } pbl_ctrl_t;

endpackage

// ===== design/pbl_cell.sv =====
// ----------------------------------------------------------------------------
// pbl_cell: one storage cell of the list
// Holds one byte and, on the broadcast command, takes the byte of its left
// or right neighbor, the new value, or the head byte to close the ring.
// ----------------------------------------------------------------------------
module pbl_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  pbl_pkg::pbl_ctrl_t ctrl,
    input  logic [7:0]        left_i,
    input  logic [7:0]        right_i,
    input  logic [7:0]        head_i,
    output logic [7:0]        q_o
);
    import pbl_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

    logic [7:0] cell_reg;
    logic [7:0] cell_next;

    // Select the byte this cell holds next
    always_comb begin
        cell_next = cell_reg;
        case (ctrl.cmd)
            CMD_INS: begin
                if (MY_IDX > ctrl.tgt) begin
                    cell_next = left_i;
                end else if (MY_IDX == ctrl.tgt) begin
                    cell_next = ctrl.value;
                end
            end
            CMD_DEL: begin
                if (MY_IDX >= ctrl.tgt) begin
                    cell_next = right_i;
                end
            end
            CMD_ROT: begin
                if (MY_IDX < ctrl.last_idx) begin
                    cell_next = right_i;
                end else if (MY_IDX == ctrl.last_idx) begin
                    cell_next = head_i;
                end
            end
            default: cell_next = cell_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign q_o = cell_reg;

endmodule

// ===== design/positional_byte_list.sv =====
// ----------------------------------------------------------------------------
// positional_byte_list: ordered list of bytes with positional insert/remove
// A row of shifting cells holds the list, head in cell 0. Inserts and most
// removes shift part of the row by one; read out rotates the used part of
// the row through cell 0, one element per cycle unless the m_ side stalls.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                          | tuser     | tlast
//  ---------+-----+--------------------------------+-----------+-------------
//  s_       | in  | [7:0] value, [12:8] position   | [2:0] op  | -
//  m_       | out | [7:0] data,  [12:8] count      | [2:0] stat| last result
//
//  Every operation but read out of a non-empty list leaves one result in the
//  output register. Read out first takes the element count and then emits the
//  elements head first, driven by the rotation of the cell row through cell 0;
//  the input is not ready until the last element has been loaded into the output register.
//  A stalled m_ side holds the output register and the row until taken.
//  Reset clears the count and the control state; cell contents are not reset.
//
module positional_byte_list #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] value, [12:8] position, zero fill
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data, [12:8] count, zero fill
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import pbl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    pbl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   rd_left_reg, rd_left_next;

    logic               m_tvalid_reg;
    pbl_status_t        m_status_reg, status_next;
    logic [7:0]         m_data_reg, data_next;
    logic [4:0]         m_count_reg;
    logic               m_last_reg, last_next;
    logic               out_load;

    pbl_ctrl_t          ctrl;
    logic [7:0]         cell_q [CAPACITY];

    logic               slot_free;
    logic               s_fire;
    pbl_op_t            op;
    logic [7:0]         pos_x;
    logic [7:0]         fill_x;
    logic               pos_ok;
    logic               is_empty;
    logic               is_full;
    logic [CNT_W+4:0]   cnt_wide;

    // Handshake
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == PBL_IDLE) && slot_free;
    assign s_fire    = s_tvalid && s_tready;

    // Request decode
    assign op       = pbl_op_t'(s_tuser);
    assign pos_x    = 8'(s_tdata[12:8]);
    assign fill_x   = 8'(fill_reg);
    assign pos_ok   = (pos_x != 8'd0) && (pos_x <= fill_x);
    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CNT_W'(CAPACITY));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PBL_IDLE: begin
                if (s_fire && op == OP_READ && !is_empty) begin
                    state_next = PBL_READ;
                end
            end
            PBL_READ: begin
                if (slot_free && rd_left_reg == CNT_W'(1)) begin
                    state_next = PBL_IDLE;
                end
            end
            default: state_next = PBL_IDLE;
        endcase
    end

    // Cell commands, count update and result selection
    always_comb begin
        ctrl.cmd      = CMD_HOLD;
        ctrl.tgt      = '0;
        ctrl.last_idx = IDX_MAX_W'(fill_reg - CNT_W'(1));
        ctrl.value    = s_tdata[7:0];
        fill_next     = fill_reg;
        rd_left_next  = rd_left_reg;
        out_load      = 1'b0;
        status_next   = ST_DONE;
        data_next     = 8'h00;
        last_next     = 1'b1;
        case (state_reg)
            PBL_IDLE: begin
                if (s_fire) begin
                    out_load = 1'b1;
                    case (op)
                        OP_CLEAR: begin
                            fill_next = '0;
                        end
                        OP_INS_HEAD: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.cmd  = CMD_INS;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_INS_TAIL: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.cmd  = CMD_INS;
                                ctrl.tgt  = IDX_MAX_W'(fill_reg);
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_INS_POS: begin
                            if (!pos_ok) begin
                                status_next = ST_BADPOS;
                            end else if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.cmd  = CMD_INS;
                                ctrl.tgt  = IDX_MAX_W'(s_tdata[12:8] - 5'd1);
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_RM_HEAD: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.cmd  = CMD_DEL;
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_RM_TAIL: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_RM_POS: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if (!pos_ok) begin
                                status_next = ST_BADPOS;
                            end else begin
                                ctrl.cmd  = CMD_DEL;
                                ctrl.tgt  = IDX_MAX_W'(s_tdata[12:8] - 5'd1);
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                out_load     = 1'b0;
                                rd_left_next = fill_reg;
                            end
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            PBL_READ: begin
                // Emit the head byte and rotate the used cells by one
                if (slot_free) begin
                    out_load     = 1'b1;
                    status_next  = ST_ELEM;
                    data_next    = cell_q[0];
                    last_next    = (rd_left_reg == CNT_W'(1));
                    ctrl.cmd     = CMD_ROT;
                    rd_left_next = rd_left_reg - CNT_W'(1);
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    assign cnt_wide = (CNT_W + 5)'(fill_next);

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [7:0] left_b;
        logic [7:0] right_b;
        if (i == 0) begin : g_first
            assign left_b = 8'h00;
        end else begin : g_mid_l
            assign left_b = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_b = cell_q[i];
        end else begin : g_mid_r
            assign right_b = cell_q[i+1];
        end
        pbl_cell #(
            .IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .left_i  (left_b),
            .right_i (right_b),
            .head_i  (cell_q[0]),
            .q_o     (cell_q[i])
        );
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= PBL_IDLE;
            fill_reg     <= '0;
            rd_left_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_left_reg <= rd_left_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output register; hold while stalled
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_next;
            m_data_reg   <= data_next;
            m_count_reg  <= cnt_wide[4:0];
            m_last_reg   <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_no_req_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PBL_READ |-> !s_tready)
        else $error("request taken during read out");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op != OP_READ |=> m_tvalid_reg && m_last_reg)
        else $error("single result missing or not marked last");

    a_read_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PBL_READ && slot_free && rd_left_reg == CNT_W'(1)
        |=> state_reg == PBL_IDLE && m_tvalid_reg && m_last_reg)
        else $error("read out did not end with a last element");
`endif

endmodule

// ===== tb/sv/positional_byte_list_tb.sv =====
// ----------------------------------------------------------------------------
// positional_byte_list_tb: self-checking bench for the positional byte list
// Drives list requests on the s_ stream and keeps its own copy of the list,
// which predicts every result. Results on the m_ stream are compared field
// by field in order. Directed edge cases, a fill to capacity, an output hold
// that backs up the input, a drain pause, and a long random run are covered.
// ----------------------------------------------------------------------------
module positional_byte_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbl_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_WAIT   = 24;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        pbl_status_t status;
        logic [7:0]  data;
        logic [4:0]  count;
        logic        last;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow of the list contents, head first
    logic [7:0]   list_bytes[$];
    list_result_t pending_results[$];
    int           mismatch_count = 0;

    // Idling controls shared between the stimulus and the receiver
    bit src_burst    = 1'b0;
    bit sink_burst   = 1'b0;
    int sink_hold_len = 0;
    bit sink_held    = 1'b0;

    positional_byte_list #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic void expect_result(pbl_status_t st, logic [7:0] data, logic last);
        list_result_t res;
        res.status = st;
        res.data   = data;
        res.count  = 5'(list_bytes.size());
        res.last   = last;
        pending_results.push_back(res);
    endfunction

    // Apply one request to the shadow list and queue the results it causes
    function automatic void predict_list_op(pbl_op_t op, logic [7:0] value, logic [4:0] pos);
        int          n;
        pbl_status_t st;
        n  = list_bytes.size();
        st = ST_DONE;
        case (op)
            OP_CLEAR: begin
                list_bytes.delete();
            end
            OP_INS_HEAD: begin
                if (n >= LIST_CAP) st = ST_FULL;
                else list_bytes.push_front(value);
            end
            OP_INS_TAIL: begin
                if (n >= LIST_CAP) st = ST_FULL;
                else list_bytes.push_back(value);
            end
            OP_INS_POS: begin
                if (pos < 1 || pos > n) st = ST_BADPOS;
                else if (n >= LIST_CAP) st = ST_FULL;
                else list_bytes.insert(pos - 1, value);
            end
            OP_RM_HEAD: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_bytes.pop_front());
            end
            OP_RM_TAIL: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_bytes.pop_back());
            end
            OP_RM_POS: begin
                if (n == 0) st = ST_EMPTY;
                else if (pos < 1 || pos > n) st = ST_BADPOS;
                else list_bytes.delete(pos - 1);
            end
            default: begin
                // Read out: one result per element, or a single empty report
                if (n == 0) begin
                    expect_result(ST_EMPTY, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        expect_result(ST_ELEM, list_bytes[i], (i == n - 1));
                end
                return;
            end
        endcase
        expect_result(st, 8'h00, 1'b1);
    endfunction

    // Offer one request, hold it until accepted, then predict its results
    task automatic send_request(pbl_op_t op, logic [7:0] value, logic [4:0] pos);
        int gap;
        gap = src_burst ? 0 : rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, value};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_list_op(op, value, pos);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Position that is legal for the length of a non-empty list most of the time,
    // and always legal for inserts into a non-empty list
    function automatic logic [4:0] pick_position(bit for_insert);
        int n;
        n = list_bytes.size();
        if (n > 0 && (for_insert || $urandom_range(0, 9) < 8))
            return 5'($urandom_range(1, n));
        return 5'($urandom_range(0, 31));
    endfunction

    // Empty-list reports, bad positions, value extremes, every operation
    task automatic test_directed();
        send_request(OP_CLEAR,    8'h00, 5'd0);
        send_request(OP_READ,     8'h00, 5'd0);
        send_request(OP_RM_HEAD,  8'h00, 5'd0);
        send_request(OP_RM_TAIL,  8'hff, 5'd31);
        send_request(OP_RM_POS,   8'h00, 5'd0);
        send_request(OP_RM_POS,   8'h00, 5'd1);
        send_request(OP_INS_POS,  8'h11, 5'd1);
        send_request(OP_INS_HEAD, 8'h00, 5'd0);
        send_request(OP_INS_TAIL, 8'hff, 5'd31);
        send_request(OP_INS_POS,  8'ha5, 5'd1);
        send_request(OP_INS_POS,  8'h5a, 5'd3);
        send_request(OP_INS_POS,  8'h77, 5'd31);
        send_request(OP_INS_POS,  8'h77, 5'd0);
        send_request(OP_READ,     8'h00, 5'd0);
        send_request(OP_RM_POS,   8'h00, 5'd0);
        send_request(OP_RM_POS,   8'h00, 5'd5);
        send_request(OP_RM_POS,   8'h00, 5'd4);
        send_request(OP_RM_POS,   8'h00, 5'd1);
        send_request(OP_READ,     8'h00, 5'd0);
        send_request(OP_RM_HEAD,  8'h00, 5'd0);
        send_request(OP_RM_TAIL,  8'h00, 5'd0);
        send_request(OP_INS_TAIL, 8'h3c, 5'd0);
        send_request(OP_CLEAR,    8'h00, 5'd0);
        send_request(OP_READ,     8'h00, 5'd0);
    endtask

    // Fill to capacity, hit the full and bad-position cases, read, clear
    task automatic test_fill_to_capacity();
        pbl_op_t op;
        for (int i = 0; i < LIST_CAP; i++) begin
            op = pbl_op_t'($urandom_range(OP_INS_HEAD, OP_INS_POS));
            if (list_bytes.size() == 0 && op == OP_INS_POS) op = OP_INS_TAIL;
            send_request(op, 8'($urandom), pick_position(1'b1));
        end
        send_request(OP_INS_HEAD, 8'($urandom), 5'd0);
        send_request(OP_INS_TAIL, 8'($urandom), 5'd0);
        send_request(OP_INS_POS,  8'($urandom), 5'd8);
        send_request(OP_INS_POS,  8'($urandom), 5'd17);
        send_request(OP_INS_POS,  8'($urandom), 5'd0);
        send_request(OP_READ,     8'h00, 5'd0);
        send_request(OP_RM_POS,   8'h00, 5'd16);
        send_request(OP_INS_POS,  8'($urandom), 5'd15);
        send_request(OP_READ,     8'h00, 5'd0);
        send_request(OP_CLEAR,    8'h00, 5'd0);
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        pbl_op_t op;
        s_tvalid <= 1'b0;
        sink_hold_len = 150;
        do @(posedge aclk); while (!sink_held);
        src_burst = 1'b1;
        for (int i = 0; i < 12; i++) begin
            op = (i % 4 == 3) ? OP_READ : pbl_op_t'($urandom_range(OP_INS_HEAD, OP_RM_POS));
            send_request(op, 8'($urandom), pick_position(1'b0));
        end
        src_burst = 1'b0;
    endtask

    // Go quiet until the block has handed back everything, then resume
    task automatic test_drain_pause();
        pause_until_drained();
        send_request(OP_READ, 8'h00, 5'd0);
        send_request(OP_INS_HEAD, 8'($urandom), 5'd0);
        pause_until_drained();
    endtask

    // Random requests in grow and shrink phases, with a little noise
    task automatic test_random_mix(int n_items);
        int      r;
        bit      growing;
        pbl_op_t op;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                src_burst  = ($urandom_range(0, 3) == 0);
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            if (k % 25 == 0) growing = $urandom_range(0, 1);
            if (k == n_items / 2) pause_until_drained();
            r = $urandom_range(0, 99);
            if (r < 6) begin
                op = pbl_op_t'($urandom_range(0, 7));
                send_request(op, 8'($urandom), 5'($urandom_range(0, 31)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) op = OP_READ;
                else if (r < 10) op = OP_CLEAR;
                else if ((r < 70) == growing)
                    op = pbl_op_t'($urandom_range(OP_INS_HEAD, OP_INS_POS));
                else
                    op = pbl_op_t'($urandom_range(OP_RM_HEAD, OP_RM_POS));
                send_request(op, 8'($urandom), pick_position(op == OP_INS_POS));
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    // Receiver: random stalls, bursts of constant ready, or a long hold
    initial begin : sink_ctrl
        int stall;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (sink_hold_len > 0) begin
                m_tready  <= 1'b0;
                sink_held = 1'b1;
                repeat (sink_hold_len) @(posedge aclk);
                sink_hold_len = 0;
                sink_held = 1'b0;
            end
            stall = sink_burst ? 0 : rand_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        list_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t unexpected result: status %0d data %h count %0d last %b",
                             $realtime, m_tuser, m_tdata[7:0], m_tdata[12:8], m_tlast);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tuser !== exp_res.status || m_tdata[7:0] !== exp_res.data ||
                    m_tdata[12:8] !== exp_res.count || m_tlast !== exp_res.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t result mismatch: expected status %0d data %h ",
                                  "count %0d last %b, got status %0d data %h count %0d last %b"},
                                 $realtime, exp_res.status, exp_res.data, exp_res.count,
                                 exp_res.last, m_tuser, m_tdata[7:0], m_tdata[12:8], m_tlast);
                end
            end
        end
    end

    // Watchdog: end the run with an error after a long stretch with no request or result moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("[positional_byte_list] ERROR");
        $finish;
    end

    initial begin : run
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_to_capacity();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix(170);
        pause_until_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[positional_byte_list] OK");
        end else begin
            $display("[positional_byte_list] ERROR");
        end
        $finish;
    end

endmodule
